// ===== rtl/bbc_pkg.sv =====
package bbc_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOT_W = 4;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_GET,
    OP_RELEASE,
    OP_DIRTY,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_NOFREE,
    ST_UNHELD
  } status_t;

  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  count;
    logic        valid;
    logic        dirty;
  } entry_t;

endpackage

// ===== rtl/bbc_in_if.sv =====
interface bbc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [3:0]  slot;

  modport source (output valid, op, device, block_number, slot, input ready);
  modport sink (input valid, op, device, block_number, slot, output ready);
endinterface

// ===== rtl/bbc_out_if.sv =====
interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] result_slot;
  logic       hit;
  logic       need_read;
  logic [1:0] status;

  modport source (output valid, result_slot, hit, need_read, status, input ready);
  modport sink (input valid, result_slot, hit, need_read, status, output ready);
endinterface

// ===== rtl/bbc_ram.sv =====
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/block_buffer_cache_lru.sv =====
// Tag and LRU replacement engine for a buffer cache of SLOTS slots. Slot entries (tag, holder
// count, valid and dirty flags) live in one memory indexed by slot, and the recency order lives
// in a second memory that lists the slots from oldest (rank 0) to most recent. After reset the
// block writes the reset contents into every entry of both memories and accepts no request until
// that is done. A get walks the order memory from the most recent rank down to the oldest, reading
// each listed slot's entry behind it, and stops early on a hit. A release that drops a count to
// zero rewrites the order list in one pass over all ranks; other releases, mark_dirty and
// disk_done leave the order list untouched.
// A new request is accepted while the previous result still waits at the output.
module block_buffer_cache_lru #(
  parameter int SLOTS = bbc_pkg::SLOTS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  bbc_in_if.sink  in_ch,
  bbc_out_if.source out_ch
);

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDENT,
    S_SCAN,
    S_SHIFT,
    S_TOP,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  bbc_pkg::op_t      op_r, op_nxt;
  logic [7:0]        dev_r, dev_nxt;
  logic [31:0]       blk_r, blk_nxt;
  logic [3:0]        slot_r, slot_nxt;

  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic              iss_on_r, iss_on_nxt;
  logic              p1_v_r, p1_v_nxt;
  logic              p1_last_r, p1_last_nxt;
  logic [SW-1:0]     p1_rank_r, p1_rank_nxt;
  logic              p2_v_r, p2_v_nxt;
  logic              p2_last_r, p2_last_nxt;
  logic [SW-1:0]     p2_slot_r, p2_slot_nxt;
  logic              cand_v_r, cand_v_nxt;
  logic [SW-1:0]     cand_r, cand_nxt;
  logic              found_r, found_nxt;

  logic [3:0]        res_slot_r, res_slot_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              res_need_r, res_need_nxt;
  bbc_pkg::status_t  res_status_r, res_status_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_slot_r, out_slot_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              out_need_r, out_need_nxt;
  bbc_pkg::status_t  out_status_r, out_status_nxt;

  logic              ent_we;
  logic [SW-1:0]     ent_waddr, ent_raddr;
  bbc_pkg::entry_t   ent_wdata, ent_rdata;
  logic              ord_we;
  logic [SW-1:0]     ord_waddr, ord_raddr, ord_wdata, ord_rdata;

  logic [SW-1:0]     slot_a;
  logic              in_oob;
  logic              tag_match;
  logic              slot_free;
  logic [SW-1:0]     miss_sel;

  bbc_ram #(
    .WIDTH($bits(bbc_pkg::entry_t)),
    .DEPTH(SLOTS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  bbc_ram #(
    .WIDTH(SW),
    .DEPTH(SLOTS)
  ) u_order_ram (
    .clk  (clk),
    .we   (ord_we),
    .waddr(ord_waddr),
    .wdata(ord_wdata),
    .raddr(ord_raddr),
    .rdata(ord_rdata)
  );

  assign slot_a    = SW'(slot_r);
  assign in_oob    = 32'(in_ch.slot) >= 32'(SLOTS);
  assign tag_match = (ent_rdata.dev == dev_r) && (ent_rdata.blk == blk_r);
  assign slot_free = (ent_rdata.count == 8'd0) && !ent_rdata.dirty;
  assign miss_sel  = slot_free ? p2_slot_r : cand_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    dev_nxt        = dev_r;
    blk_nxt        = blk_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    iss_on_nxt     = iss_on_r;
    p1_v_nxt       = p1_v_r;
    p1_last_nxt    = p1_last_r;
    p1_rank_nxt    = p1_rank_r;
    p2_v_nxt       = p2_v_r;
    p2_last_nxt    = p2_last_r;
    p2_slot_nxt    = p2_slot_r;
    cand_v_nxt     = cand_v_r;
    cand_nxt       = cand_r;
    found_nxt      = found_r;
    res_slot_nxt   = res_slot_r;
    res_hit_nxt    = res_hit_r;
    res_need_nxt   = res_need_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_slot_nxt   = out_slot_r;
    out_hit_nxt    = out_hit_r;
    out_need_nxt   = out_need_r;
    out_status_nxt = out_status_r;
    ent_we         = 1'b0;
    ent_waddr      = slot_a;
    ent_wdata      = ent_rdata;
    ent_raddr      = slot_a;
    ord_we         = 1'b0;
    ord_waddr      = cnt_r;
    ord_wdata      = cnt_r;
    ord_raddr      = cnt_r;
    in_ch.ready    = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = cnt_r;
        ent_wdata = '0;
        ord_we    = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ch.ready = 1'b1;
        ent_raddr   = SW'(in_ch.slot);
        if (in_ch.valid) begin
          op_nxt         = bbc_pkg::op_t'(in_ch.op);
          dev_nxt        = in_ch.device;
          blk_nxt        = in_ch.block_number;
          slot_nxt       = in_ch.slot;
          res_slot_nxt   = in_ch.slot;
          res_hit_nxt    = 1'b0;
          res_need_nxt   = 1'b0;
          res_status_nxt = bbc_pkg::ST_DONE;
          if (in_ch.op == bbc_pkg::OP_GET) begin
            state_nxt  = S_SCAN;
            cnt_nxt    = LAST;
            iss_on_nxt = 1'b1;
            p1_v_nxt   = 1'b0;
            p2_v_nxt   = 1'b0;
            cand_v_nxt = 1'b0;
          end else if (in_oob) begin
            state_nxt = S_RESP;
            if (in_ch.op == bbc_pkg::OP_RELEASE) begin
              res_status_nxt = bbc_pkg::ST_UNHELD;
            end
          end else begin
            state_nxt = S_RDENT;
          end
        end
      end

      S_RDENT: begin
        state_nxt = S_RESP;
        case (op_r)
          bbc_pkg::OP_RELEASE: begin
            if (ent_rdata.count == 8'd0) begin
              res_status_nxt = bbc_pkg::ST_UNHELD;
            end else begin
              ent_we          = 1'b1;
              ent_wdata.count = ent_rdata.count - 8'd1;
              if (ent_rdata.count == 8'd1) begin
                state_nxt  = S_SHIFT;
                cnt_nxt    = '0;
                iss_on_nxt = 1'b1;
                p1_v_nxt   = 1'b0;
                found_nxt  = 1'b0;
              end
            end
          end
          bbc_pkg::OP_DIRTY: begin
            ent_we          = 1'b1;
            ent_wdata.dirty = 1'b1;
          end
          default: begin
            ent_we          = 1'b1;
            ent_wdata.valid = 1'b1;
            ent_wdata.dirty = 1'b0;
          end
        endcase
      end

      S_SCAN: begin
        p1_v_nxt = 1'b0;
        if (iss_on_r) begin
          p1_v_nxt    = 1'b1;
          p1_last_nxt = (cnt_r == '0);
          cnt_nxt     = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            iss_on_nxt = 1'b0;
          end
        end
        ent_raddr   = ord_rdata;
        p2_v_nxt    = p1_v_r;
        p2_last_nxt = p1_last_r;
        p2_slot_nxt = ord_rdata;
        if (p2_v_r) begin
          if (tag_match) begin
            ent_we    = 1'b1;
            ent_waddr = p2_slot_r;
            if (ent_rdata.count != bbc_pkg::COUNT_MAX) begin
              ent_wdata.count = ent_rdata.count + 8'd1;
            end
            res_slot_nxt = 4'(p2_slot_r);
            res_hit_nxt  = 1'b1;
            res_need_nxt = !ent_rdata.valid;
            state_nxt    = S_RESP;
            iss_on_nxt   = 1'b0;
            p1_v_nxt     = 1'b0;
            p2_v_nxt     = 1'b0;
          end else begin
            if (slot_free) begin
              cand_v_nxt = 1'b1;
              cand_nxt   = p2_slot_r;
            end
            if (p2_last_r) begin
              state_nxt = S_RESP;
              p2_v_nxt  = 1'b0;
              if (slot_free || cand_v_r) begin
                ent_we       = 1'b1;
                ent_waddr    = miss_sel;
                ent_wdata    = '{dev: dev_r, blk: blk_r, count: 8'd1, valid: 1'b0, dirty: 1'b0};
                res_slot_nxt = 4'(miss_sel);
                res_need_nxt = 1'b1;
              end else begin
                res_slot_nxt   = 4'd0;
                res_status_nxt = bbc_pkg::ST_NOFREE;
              end
            end
          end
        end
      end

      S_SHIFT: begin
        p1_v_nxt = 1'b0;
        if (iss_on_r) begin
          p1_v_nxt    = 1'b1;
          p1_rank_nxt = cnt_r;
          p1_last_nxt = (cnt_r == LAST);
          cnt_nxt     = cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            iss_on_nxt = 1'b0;
          end
        end
        if (p1_v_r) begin
          if (found_r) begin
            ord_we    = 1'b1;
            ord_waddr = p1_rank_r - 1'b1;
            ord_wdata = ord_rdata;
          end else if (ord_rdata == slot_a) begin
            found_nxt = 1'b1;
          end
          if (p1_last_r) begin
            state_nxt = S_TOP;
          end
        end
      end

      S_TOP: begin
        ord_we    = 1'b1;
        ord_waddr = LAST;
        ord_wdata = slot_a;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r;
          out_hit_nxt    = res_hit_r;
          out_need_nxt   = res_need_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    dev_r        <= dev_nxt;
    blk_r        <= blk_nxt;
    slot_r       <= slot_nxt;
    p1_last_r    <= p1_last_nxt;
    p1_rank_r    <= p1_rank_nxt;
    p2_last_r    <= p2_last_nxt;
    p2_slot_r    <= p2_slot_nxt;
    cand_r       <= cand_nxt;
    res_slot_r   <= res_slot_nxt;
    res_hit_r    <= res_hit_nxt;
    res_need_r   <= res_need_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_need_r   <= out_need_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      iss_on_r    <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      cand_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      iss_on_r    <= iss_on_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      cand_v_r    <= cand_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_slot = out_slot_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.need_read   = out_need_r;
  assign out_ch.status      = out_status_r;

endmodule

// ===== rtl/bbc_checker.sv =====
module bbc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_result_slot,
  input logic       out_hit,
  input logic       out_need_read,
  input logic [1:0] out_status
);

  // Reset starts the memory initialization, so nothing is taken or offered right after it.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("request accepted or result offered right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_slot) && $stable(out_hit)
      && $stable(out_need_read) && $stable(out_status))
    else $error("stalled result changed before its transfer");

  a_nofree_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bbc_pkg::ST_NOFREE |->
      out_result_slot == 4'd0 && !out_hit && !out_need_read)
    else $error("no-free-buffer result carries a slot or flags");

  a_flags_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit || out_need_read) |-> out_status == bbc_pkg::ST_DONE)
    else $error("hit or need_read raised on a failed request");

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_result_slot(out_ch.result_slot),
  .out_hit        (out_ch.hit),
  .out_need_read  (out_ch.need_read),
  .out_status     (out_ch.status)
);
